// ===== sv/wrst_pkg.sv =====
// shared types and constants for the weighted random state transition block
// no dependencies
`default_nettype none

package wrst_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int WT_W          = 16;
    localparam int RND_W         = 16;
    localparam int SUM_W         = WT_W + IDX_W;
    localparam int PROD_W        = RND_W + SUM_W;

    localparam logic [WT_W-1:0] WEIGHT_ONE = WT_W'(16'h0100);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_MATCH = 2'd1,
        STATUS_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic            any;
        logic [7:0]      src_state;
        logic [7:0]      dst_state;
        logic [7:0]      ev_code;
        logic [WT_W-1:0] weight;
    } t_entry;

endpackage

`default_nettype wire

// ===== sv/weighted_random_state_transition.sv =====
// top level of the weighted random state transition block
// depends on wrst_pkg
`default_nettype none

// Programmable stochastic state machine. An add request appends one transition
// to a table of wrst_pkg::TABLE_ENTRIES entries. An event request walks the
// table at one entry per cycle: a first pass fires the oldest matching
// any-state entry or sums the matching weights, a multiply state forms the
// threshold with a single multiplier, and a second pass walks the table again
// to pick the entry. An event ends early when an any-state entry or the pick
// comes early, and its result waits in the response state only while a
// previous result is still held by a stalled result stream. One request is in
// flight at a time; a finished result waits in the output register while the
// next request is taken.
module weighted_random_state_transition (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // any_state, src_state, dst_state, ev_code, weight, random_value, zero fill
    input  wire logic [63:0] i_s_axis_tdata,
    // operation
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // state_now, moved, fired_entry, status, zero fill
    output logic [15:0]      o_m_axis_tdata
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SUM    = 5'b00010,
        S_MULT   = 5'b00100,
        S_SELECT = 5'b01000,
        S_RESP   = 5'b10000
    } t_state;

    localparam int IDX_W  = wrst_pkg::IDX_W;
    localparam int CNT_W  = wrst_pkg::CNT_W;
    localparam int SUM_W  = wrst_pkg::SUM_W;
    localparam int PROD_W = wrst_pkg::PROD_W;
    localparam int RND_W  = wrst_pkg::RND_W;

    wrst_pkg::t_entry r_table [wrst_pkg::TABLE_ENTRIES];

    t_state              r_state,    n_state;
    logic [CNT_W-1:0]    r_count,    n_count;
    logic [7:0]          r_cur,      n_cur;
    logic [CNT_W-1:0]    r_idx,      n_idx;
    logic [7:0]          r_ev,       n_ev;
    logic [RND_W-1:0]    r_rnd,      n_rnd;
    logic [SUM_W-1:0]    r_total,    n_total;
    logic [SUM_W-1:0]    r_run,      n_run;
    logic [SUM_W-1:0]    r_thr,      n_thr;
    logic                r_found,    n_found;
    logic                r_moved,    n_moved;
    logic [3:0]          r_fired,    n_fired;
    wrst_pkg::t_status   r_status,   n_status;
    logic                r_out_valid, n_out_valid;
    logic [15:0]         r_out_data,  n_out_data;

    logic                in_accept;
    logic                in_op;
    wrst_pkg::t_entry    in_entry;
    logic                wr_en;
    wrst_pkg::t_entry    ent;
    logic                ev_hit;
    logic                norm_hit;
    logic [CNT_W-1:0]    idx_inc;
    logic                last;
    logic [SUM_W-1:0]    run_sum;
    logic [PROD_W-1:0]   prod;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op           = i_s_axis_tuser;

    always_comb begin
        in_entry.any       = i_s_axis_tdata[0];
        in_entry.src_state = i_s_axis_tdata[8:1];
        in_entry.dst_state = i_s_axis_tdata[16:9];
        in_entry.ev_code   = i_s_axis_tdata[24:17];
        in_entry.weight    = i_s_axis_tdata[0] ? wrst_pkg::WEIGHT_ONE
                                               : i_s_axis_tdata[40:25];
    end

    assign ent      = r_table[r_idx[IDX_W-1:0]];
    assign ev_hit   = (ent.ev_code == r_ev);
    assign norm_hit = !ent.any && (ent.src_state == r_cur) && ev_hit;
    assign idx_inc  = r_idx + CNT_W'(1);
    assign last     = (idx_inc == r_count);
    assign run_sum  = r_run + SUM_W'(ent.weight);
    assign prod     = PROD_W'(r_rnd) * PROD_W'(r_total);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_idx       = r_idx;
        n_ev        = r_ev;
        n_rnd       = r_rnd;
        n_total     = r_total;
        n_run       = r_run;
        n_thr       = r_thr;
        n_found     = r_found;
        n_moved     = r_moved;
        n_fired     = r_fired;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_ev    = i_s_axis_tdata[24:17];
                    n_rnd   = i_s_axis_tdata[56:41];
                    n_moved = 1'b0;
                    n_fired = 4'd0;
                    n_idx   = '0;
                    n_total = '0;
                    n_run   = '0;
                    n_found = 1'b0;
                    n_state = S_RESP;
                    if (in_op == wrst_pkg::OP_ADD) begin
                        if (r_count == CNT_W'(wrst_pkg::TABLE_ENTRIES)) begin
                            n_status = wrst_pkg::STATUS_FULL;
                        end else begin
                            wr_en    = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_status = wrst_pkg::STATUS_OK;
                        end
                    end else if (r_count == '0) begin
                        n_status = wrst_pkg::STATUS_NO_MATCH;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                // any-state entries win outright, oldest first
                if (ent.any && ev_hit) begin
                    n_cur    = ent.dst_state;
                    n_moved  = 1'b1;
                    n_fired  = 4'(r_idx);
                    n_status = wrst_pkg::STATUS_OK;
                    n_state  = S_RESP;
                end else begin
                    if (norm_hit) begin
                        n_total = r_total + SUM_W'(ent.weight);
                        n_found = 1'b1;
                    end
                    n_idx = idx_inc;
                    if (last) begin
                        if (r_found || norm_hit) begin
                            n_state = S_MULT;
                        end else begin
                            n_status = wrst_pkg::STATUS_NO_MATCH;
                            n_state  = S_RESP;
                        end
                    end
                end
            end
            S_MULT: begin
                n_thr   = prod[PROD_W-1:RND_W];
                n_idx   = '0;
                n_run   = '0;
                n_state = S_SELECT;
            end
            S_SELECT: begin
                if (norm_hit && (run_sum >= r_thr)) begin
                    n_cur    = ent.dst_state;
                    n_moved  = 1'b1;
                    n_fired  = 4'(r_idx);
                    n_status = wrst_pkg::STATUS_OK;
                    n_state  = S_RESP;
                end else begin
                    if (norm_hit) begin
                        n_run = run_sum;
                    end
                    n_idx = idx_inc;
                    if (last) begin
                        n_status = wrst_pkg::STATUS_NO_MATCH;
                        n_state  = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_status, r_fired, r_moved, r_cur};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_ev       <= n_ev;
        r_rnd      <= n_rnd;
        r_total    <= n_total;
        r_run      <= n_run;
        r_thr      <= n_thr;
        r_found    <= n_found;
        r_moved    <= n_moved;
        r_fired    <= n_fired;
        r_status   <= n_status;
        r_out_data <= n_out_data;
        if (wr_en) begin
            r_table[r_count[IDX_W-1:0]] <= in_entry;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // table fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(wrst_pkg::TABLE_ENTRIES))
        else $error("entry count beyond table depth");

    // a dropped add leaves the table untouched
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (in_op == wrst_pkg::OP_ADD)
            && (r_count == CNT_W'(wrst_pkg::TABLE_ENTRIES))
        |=> $stable(r_count) && (r_status == wrst_pkg::STATUS_FULL))
        else $error("full table changed on add");

    // the current state only moves when a transition fires
    a_state_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) && !r_moved |-> $stable(r_cur))
        else $error("state changed without a fired transition");

endmodule

`default_nettype wire

// ===== tb/tb_weighted_random_state_transition.sv =====
// self-checking testbench for weighted_random_state_transition: a directed table setup and event sequence,
// then random add and event requests with random stalls on both streams
// depends on wrst_pkg and weighted_random_state_transition
`timescale 1ns / 100ps

module tb_weighted_random_state_transition;

    import wrst_pkg::*;

    localparam int RANDOM_REQUESTS = 1782;
    localparam int IDLE_PERCENT    = 19;
    localparam logic [7:0] HOME_EVENT = 8'hC8;

    typedef struct packed {
        logic [7:0] state_now;
        logic       moved;
        logic [3:0] fired_entry;
        t_status    status;
    } t_outcome;

    class transition_scoreboard;
        t_entry     entries [TABLE_ENTRIES];
        int         stored;
        logic [7:0] state_reg;
        t_outcome   expected_results [$];
        int         errors;
        int         mismatches;

        function new();
            stored     = 0;
            state_reg  = 8'h00;
            errors     = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(logic op, logic [63:0] d);
            t_entry     ent;
            t_outcome   res;
            logic [7:0] ev;
            logic [63:0] rnd, total, thr, run;
            bit         found, done;
            ev    = d[24:17];
            rnd   = {48'd0, d[56:41]};
            res   = '{state_now: 8'h00, moved: 1'b0, fired_entry: 4'h0, status: STATUS_OK};
            done  = 0;
            found = 0;
            total = 0;
            run   = 0;
            if (op == OP_ADD) begin
                if (stored >= TABLE_ENTRIES) begin
                    res.status = STATUS_FULL;
                end else begin
                    ent.any        = d[0];
                    ent.src_state  = d[8:1];
                    ent.dst_state  = d[16:9];
                    ent.ev_code    = ev;
                    ent.weight     = d[0] ? WEIGHT_ONE : d[40:25];
                    entries[stored] = ent;
                    stored++;
                end
            end else begin
                // oldest any-state entry for the event wins outright
                for (int i = 0; i < stored; i++) begin
                    if (!done && entries[i].any && entries[i].ev_code == ev) begin
                        state_reg       = entries[i].dst_state;
                        res.moved       = 1'b1;
                        res.fired_entry = 4'(i);
                        done            = 1;
                    end
                end
                if (!done) begin
                    for (int i = 0; i < stored; i++) begin
                        if (!entries[i].any && entries[i].src_state == state_reg &&
                            entries[i].ev_code == ev) begin
                            total += {48'd0, entries[i].weight};
                            found = 1;
                        end
                    end
                    if (!found) begin
                        res.status = STATUS_NO_MATCH;
                    end else begin
                        thr = (rnd * total) >> 16;
                        for (int i = 0; i < stored; i++) begin
                            if (!done && !entries[i].any && entries[i].src_state == state_reg &&
                                entries[i].ev_code == ev) begin
                                run += {48'd0, entries[i].weight};
                                if (run >= thr) begin
                                    state_reg       = entries[i].dst_state;
                                    res.moved       = 1'b1;
                                    res.fired_entry = 4'(i);
                                    done            = 1;
                                end
                            end
                        end
                    end
                end
            end
            res.state_now = state_reg;
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [15:0] d);
            t_outcome exp;
            if (expected_results.size() == 0) begin
                errors++;
                if (mismatches < 10) begin
                    $display("unexpected result %0h", d);
                end
                mismatches++;
                return;
            end
            exp = expected_results.pop_front();
            if (d[7:0] !== exp.state_now || d[8] !== exp.moved ||
                d[12:9] !== exp.fired_entry || d[14:13] !== exp.status) begin
                errors++;
                if (mismatches < 10) begin
                    $display("mismatch: expected state %0h moved %0b entry %0d status %0d",
                             exp.state_now, exp.moved, exp.fired_entry, exp.status);
                    $display("          got state %0h moved %0b entry %0d status %0d",
                             d[7:0], d[8], d[12:9], d[14:13]);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // any_state, src_state, dst_state, ev_code, weight, random_value, zero fill
    logic [63:0] i_s_axis_tdata = 64'd0;
    // operation
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // state_now, moved, fired_entry, status, zero fill
    logic [15:0] o_m_axis_tdata;

    bit steady = 0;
    transition_scoreboard sb = new();

    weighted_random_state_transition i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_request(i_s_axis_tuser, i_s_axis_tdata);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_result(o_m_axis_tdata);
            end
        end
    end

    task automatic send_request(input logic op, input logic any, input logic [7:0] from_s,
                                input logic [7:0] to_s, input logic [7:0] ev,
                                input logic [15:0] wt, input logic [15:0] rnd);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {7'd0, rnd, wt, ev, to_s, from_s, any};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_add(input logic any, input logic [7:0] from_s, input logic [7:0] to_s,
                            input logic [7:0] ev, input logic [15:0] wt);
        send_request(OP_ADD, any, from_s, to_s, ev, wt, 16'($urandom));
    endtask

    task automatic send_event(input logic [7:0] ev, input logic [15:0] rnd);
        send_request(OP_EVENT, 1'($urandom), 8'($urandom), 8'($urandom), ev, 16'($urandom), rnd);
    endtask

    function automatic logic [7:0] pick_state();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h02;
            3: return 8'h03;
            4: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_event();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h02;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [15:0] pick_edge16();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        #5_000_000;
        $display("tb_weighted_random_state_transition: FAIL");
        $finish;
    end

    initial begin
        logic [7:0] ev;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table
        send_event(8'h00, 16'h0000);
        send_add(1'b0, 8'h00, 8'h01, 8'h00, 16'h0100);
        send_add(1'b0, 8'h00, 8'h02, 8'h00, 16'hFFFF);
        // all-zero weights, first match fires
        send_add(1'b0, 8'h01, 8'hFF, 8'hFF, 16'h0000);
        send_add(1'b0, 8'h01, 8'h00, 8'hFF, 16'h0000);
        send_add(1'b0, 8'hFF, 8'h03, 8'h01, 16'h0080);
        // two any-state entries on one event, older wins, weight ignored
        send_add(1'b1, 8'hAA, 8'h00, HOME_EVENT, 16'hFFFF);
        send_add(1'b1, 8'h55, 8'h55, HOME_EVENT, 16'h0000);
        send_add(1'b0, 8'h03, 8'h00, 8'h02, 16'h8000);
        send_add(1'b0, 8'h02, 8'h01, 8'h01, 16'h0001);
        send_event(8'h00, 16'h0000);
        send_event(8'hFF, 16'hFFFF);
        send_event(8'h01, 16'h8000);
        send_event(8'h02, 16'h1234);
        send_event(8'h00, 16'hFFFF);
        send_event(8'h01, 16'($urandom));
        send_event(HOME_EVENT, 16'($urandom));
        // no match
        send_event(8'h77, 16'($urandom));

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            steady = (n >= 500 && n < 800);
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 9) == 0) begin
                    ev = ($urandom_range(0, 1) == 0) ? HOME_EVENT : 8'($urandom_range(128, 254));
                    send_add(1'b1, 8'($urandom), 8'($urandom), ev, 16'($urandom));
                end else begin
                    send_add(1'b0, pick_state(), pick_state(), pick_event(), pick_edge16());
                end
            end else begin
                case ($urandom_range(0, 99))
                    0, 1, 2, 3, 4, 5, 6, 7: ev = HOME_EVENT;
                    8, 9, 10, 11, 12:       ev = 8'($urandom);
                    default:                ev = pick_event();
                endcase
                send_event(ev, pick_edge16());
            end
        end
        steady = 0;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_weighted_random_state_transition: PASS");
        end else begin
            $display("tb_weighted_random_state_transition: FAIL");
        end
        $finish;
    end

endmodule

// ===== weighted_random_state_transition.f =====
sv/wrst_pkg.sv
sv/weighted_random_state_transition.sv
tb/tb_weighted_random_state_transition.sv
